>>> hdl/d2c_pkg.sv
// ----------------------------------------------------------------------------
// d2c_pkg
// shared types, register indexes and reset values for depth to colour
// registration
// ----------------------------------------------------------------------------
package d2c_pkg;

   localparam int DEF_IMAGE_WIDTH  = 640;
   localparam int DEF_IMAGE_HEIGHT = 480;

   // register indexes on the csr port
   localparam logic [2:0] CSR_DEPTH_INV_FOCAL = 3'd0;
   localparam logic [2:0] CSR_DEPTH_PRINCIPAL = 3'd1;
   localparam logic [2:0] CSR_COLOR_FOCAL     = 3'd2;
   localparam logic [2:0] CSR_COLOR_PRINCIPAL = 3'd3;
   localparam logic [2:0] CSR_POSE_ROW_X      = 3'd4;
   localparam logic [2:0] CSR_POSE_ROW_Y      = 3'd5;
   localparam logic [2:0] CSR_POSE_ROW_Z      = 3'd6;
   localparam logic [2:0] CSR_DEPTH_LIMITS    = 3'd7;

   // reset values
   localparam logic [47:0] RST_DEPTH_INV_FOCAL = 48'd536149523669;
   localparam logic [39:0] RST_DEPTH_PRINCIPAL = 40'd64290373504;
   localparam logic [39:0] RST_COLOR_FOCAL     = 40'd140928748800;
   localparam logic [39:0] RST_COLOR_PRINCIPAL = 40'd64290373504;
   localparam logic [63:0] RST_POSE_ROW_X      = 64'd16384;
   localparam logic [63:0] RST_POSE_ROW_Y      = 64'd1073741824;
   localparam logic [63:0] RST_POSE_ROW_Z      = 64'd70368744177664;
   localparam logic [31:0] RST_DEPTH_LIMITS    = 32'd655360300;

   // width of the projection numerator and denominator
   localparam int NUM_W = 64;
   localparam int DEN_W = 50;

   typedef struct packed {
      logic [47:0] depth_inv_focal;
      logic [39:0] depth_principal;
      logic [39:0] color_focal;
      logic [39:0] color_principal;
      logic [63:0] pose_row_x;
      logic [63:0] pose_row_y;
      logic [63:0] pose_row_z;
      logic [31:0] depth_limits;
   } d2c_cfg_type;

   // front end result, handed to the projection dividers
   typedef struct packed {
      logic                    valid;
      logic                    depth_ok;
      logic                    z_pos;
      logic signed [15:0]      pt_x;
      logic signed [15:0]      pt_y;
      logic signed [15:0]      pt_z;
      logic signed [NUM_W-1:0] num_u;
      logic signed [NUM_W-1:0] num_v;
      logic [DEN_W-1:0]        den;
   } d2c_front_type;

endpackage

>>> hdl/d2c_front.sv
// ----------------------------------------------------------------------------
// d2c_front
// eight stage pipeline: limit check, back-projection, pose and projection
// numerators
// ----------------------------------------------------------------------------
module d2c_front
   import d2c_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [9:0]    pixel_column,
   input  logic [8:0]    pixel_row,
   input  logic [15:0]   depth_mm,
   input  d2c_cfg_type   cfg,
   output d2c_front_type front
);

   logic [7:0] valid_ff;

   logic               ok_ff [8];
   logic signed [20:0] ax1_ff, ay1_ff;
   logic [15:0]        d1_ff, d2_ff, d3_ff;
   logic signed [37:0] mx2_ff, my2_ff;
   logic signed [61:0] xs3_ff, ys3_ff;
   logic signed [37:0] xd4_ff, yd4_ff;
   logic [23:0]        zd4_ff;
   logic signed [53:0] prod5_ff [3][3];
   logic signed [15:0] t5_ff [3];
   logic signed [41:0] p6_ff [3];
   logic signed [41:0] p6_in [3];
   logic signed [15:0] pt7_ff [3];
   logic signed [15:0] pt7_in [3];
   logic signed [62:0] ux7_ff, cu7_ff, vy7_ff, cv7_ff;
   logic               zpos7_ff;
   logic [DEN_W-1:0]   den7_ff;
   logic signed [15:0] pt8_ff [3];
   logic signed [NUM_W-1:0] nu8_ff, nv8_ff;
   logic               zpos8_ff;
   logic [DEN_W-1:0]   den8_ff;

   logic [63:0] rows [3];
   assign rows[0] = cfg.pose_row_x;
   assign rows[1] = cfg.pose_row_y;
   assign rows[2] = cfg.pose_row_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[6:0], in_valid};
      end
   end

   // pose sum and rounding to q.8 mm, then rounding to whole mm with saturation
   always_comb begin
      logic signed [55:0] acc;
      logic signed [41:0] r8;
      for (int i = 0; i < 3; i++) begin
         acc = 56'(prod5_ff[i][0]) + 56'(prod5_ff[i][1]) + 56'(prod5_ff[i][2])
             + (56'(t5_ff[i]) <<< 22);
         p6_in[i] = 42'((acc + 56'sd8192) >>> 14);
      end
      for (int i = 0; i < 3; i++) begin
         r8 = (p6_ff[i] + 42'sd128) >>> 8;
         if (r8 > 42'sd32767) begin
            pt7_in[i] = 16'sh7fff;
         end else if (r8 < -42'sd32768) begin
            pt7_in[i] = -16'sh8000;
         end else begin
            pt7_in[i] = 16'(r8);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // limit check and pixel offset from principal point
         ok_ff[0] <= (depth_mm >= cfg.depth_limits[15:0]) &&
                     (depth_mm <= cfg.depth_limits[31:16]);
         ax1_ff <= $signed({3'b0, pixel_column, 8'b0})
                 - $signed({1'b0, cfg.depth_principal[19:0]});
         ay1_ff <= $signed({4'b0, pixel_row, 8'b0})
                 - $signed({1'b0, cfg.depth_principal[39:20]});
         d1_ff  <= depth_mm;
         // scale by depth
         mx2_ff <= ax1_ff * $signed({1'b0, d1_ff});
         my2_ff <= ay1_ff * $signed({1'b0, d1_ff});
         d2_ff  <= d1_ff;
         // scale by inverse focal
         xs3_ff <= mx2_ff * $signed({1'b0, cfg.depth_inv_focal[23:0]});
         ys3_ff <= my2_ff * $signed({1'b0, cfg.depth_inv_focal[47:24]});
         d3_ff  <= d2_ff;
         // round to q.8 mm
         xd4_ff <= 38'((xs3_ff + 62'sd8388608) >>> 24);
         yd4_ff <= 38'((ys3_ff + 62'sd8388608) >>> 24);
         zd4_ff <= {d3_ff, 8'b0};
         // rotation products
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i][0] <= $signed(rows[i][15:0]) * xd4_ff;
            prod5_ff[i][1] <= $signed(rows[i][31:16]) * yd4_ff;
            prod5_ff[i][2] <= $signed(rows[i][47:32]) * $signed({1'b0, zd4_ff});
            t5_ff[i]       <= $signed(rows[i][63:48]);
         end
         for (int i = 0; i < 3; i++) begin
            p6_ff[i]  <= p6_in[i];
            pt7_ff[i] <= pt7_in[i];
            pt8_ff[i] <= pt7_ff[i];
         end
         // projection products
         ux7_ff   <= p6_ff[0] * $signed({1'b0, cfg.color_focal[19:0]});
         cu7_ff   <= $signed({1'b0, cfg.color_principal[19:0]}) * p6_ff[2];
         vy7_ff   <= p6_ff[1] * $signed({1'b0, cfg.color_focal[39:20]});
         cv7_ff   <= $signed({1'b0, cfg.color_principal[39:20]}) * p6_ff[2];
         zpos7_ff <= p6_ff[2] > 42'sd0;
         den7_ff  <= {p6_ff[2], 8'b0};
         // numerators
         nu8_ff   <= NUM_W'(ux7_ff) + NUM_W'(cu7_ff);
         nv8_ff   <= NUM_W'(vy7_ff) + NUM_W'(cv7_ff);
         zpos8_ff <= zpos7_ff;
         den8_ff  <= den7_ff;
         for (int s = 1; s < 8; s++) begin
            ok_ff[s] <= ok_ff[s-1];
         end
      end
   end

   always_comb begin
      front.valid    = valid_ff[7];
      front.depth_ok = ok_ff[7];
      front.z_pos    = zpos8_ff;
      front.pt_x     = pt8_ff[0];
      front.pt_y     = pt8_ff[1];
      front.pt_z     = pt8_ff[2];
      front.num_u    = nu8_ff;
      front.num_v    = nv8_ff;
      front.den      = den8_ff;
   end

endmodule

>>> hdl/d2c_divider.sv
// ----------------------------------------------------------------------------
// d2c_divider
// pipelined restoring divider, one quotient bit per stage, floor quotient of
// a numerator, with fits set when it lies in [0, den << QW)
// ----------------------------------------------------------------------------
module d2c_divider
   import d2c_pkg::*;
#(
   parameter int QW = 10
)
(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic [QW-1:0]           quo,
   output logic                    fits
);

   logic [NUM_W-1:0] r_ff [QW];
   logic [QW-1:0]    q_ff [QW];
   logic [DEN_W-1:0] d_ff [QW];
   logic             f_ff [QW];

   logic [NUM_W-1:0] r_src [QW];
   logic [QW-1:0]    q_src [QW];
   logic [DEN_W-1:0] d_src [QW];
   logic             f_src [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic [NUM_W-1:0] trial;
      logic             ge;
      if (j == 0) begin : g_first
         // numerator must be non-negative and give a quotient below 2^QW
         assign r_src[j] = NUM_W'(num);
         assign q_src[j] = '0;
         assign d_src[j] = den;
         assign f_src[j] = !num[NUM_W-1] &&
                           (NUM_W'(num) < (NUM_W'(den) << QW));
      end else begin : g_next
         assign r_src[j] = r_ff[j-1];
         assign q_src[j] = q_ff[j-1];
         assign d_src[j] = d_ff[j-1];
         assign f_src[j] = f_ff[j-1];
      end
      assign trial = NUM_W'(d_src[j]) << (QW - 1 - j);
      assign ge    = r_src[j] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j] <= ge ? r_src[j] - trial : r_src[j];
            q_ff[j] <= {q_src[j][QW-2:0], ge};
            d_ff[j] <= d_src[j];
            f_ff[j] <= f_src[j];
         end
      end
   end

   assign quo  = q_ff[QW-1];
   assign fits = f_ff[QW-1];

endmodule

>>> hdl/depth_to_color_registration_core.sv
// ----------------------------------------------------------------------------
// depth_to_color_registration_core
// registers one depth pixel into the colour camera image
// ----------------------------------------------------------------------------
// Takes one depth item per clock while the pipe is not stalled and returns
// one result item per input, in order. The pipe is eight front stages (limit
// check, back-projection, rigid pose, projection numerators), one pipelined
// divider stage per target bit, QW = clog2(max(IMAGE_WIDTH, IMAGE_HEIGHT))
// (QW = 10 at 640x480), then the output register. Throughput is one item per
// cycle; the whole pipe holds while the output item waits on rsp_tready.
// Configuration registers are written over the csr port, which is always
// ready, and must only be written while no item is in flight.
module depth_to_color_registration_core
   import d2c_pkg::*;
#(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
)
(
   input  logic        clock,
   input  logic        reset,
   // depth item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pixel_column[9:0], pixel_row[18:10], depth_mm[34:19]
   // result item out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // point_x_mm[15:0], point_y_mm[31:16], point_z_mm[47:32],
                                    // target_column[57:48], target_row[66:58]
   output logic [1:0]  rsp_tuser,   // depth_ok[0], in_image[1]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
   localparam int QW      = $clog2(MAX_DIM);

   // sideband that rides beside the dividers
   typedef struct packed {
      logic               depth_ok;
      logic               z_pos;
      logic signed [15:0] pt_x;
      logic signed [15:0] pt_y;
      logic signed [15:0] pt_z;
   } side_type;

   d2c_cfg_type   cfg_ff;
   d2c_front_type front;
   logic          en;

   logic [QW-1:0] side_valid_ff;
   side_type      side_ff [QW];

   logic [QW-1:0] quo_u, quo_v;
   logic          fits_u, fits_v;
   logic          u_in, v_in, hit;

   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   // ----- configuration registers -----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_inv_focal <= RST_DEPTH_INV_FOCAL;
         cfg_ff.depth_principal <= RST_DEPTH_PRINCIPAL;
         cfg_ff.color_focal     <= RST_COLOR_FOCAL;
         cfg_ff.color_principal <= RST_COLOR_PRINCIPAL;
         cfg_ff.pose_row_x      <= RST_POSE_ROW_X;
         cfg_ff.pose_row_y      <= RST_POSE_ROW_Y;
         cfg_ff.pose_row_z      <= RST_POSE_ROW_Z;
         cfg_ff.depth_limits    <= RST_DEPTH_LIMITS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEPTH_INV_FOCAL: cfg_ff.depth_inv_focal <= csr_data[47:0];
            CSR_DEPTH_PRINCIPAL: cfg_ff.depth_principal <= csr_data[39:0];
            CSR_COLOR_FOCAL:     cfg_ff.color_focal     <= csr_data[39:0];
            CSR_COLOR_PRINCIPAL: cfg_ff.color_principal <= csr_data[39:0];
            CSR_POSE_ROW_X:      cfg_ff.pose_row_x      <= csr_data;
            CSR_POSE_ROW_Y:      cfg_ff.pose_row_y      <= csr_data;
            CSR_POSE_ROW_Z:      cfg_ff.pose_row_z      <= csr_data;
            CSR_DEPTH_LIMITS:    cfg_ff.depth_limits    <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // ----- global pipe enable: advance unless the output item is stalled -----
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // ----- front end: limits, back-projection, pose, numerators -----
   d2c_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_tvalid),
      .pixel_column (req_tdata[9:0]),
      .pixel_row    (req_tdata[18:10]),
      .depth_mm     (req_tdata[34:19]),
      .cfg          (cfg_ff),
      .front        (front)
   );

   // ----- projection dividers, column and row lanes -----
   d2c_divider #(.QW(QW)) u_div_u (
      .clock (clock),
      .en    (en),
      .num   (front.num_u),
      .den   (front.den),
      .quo   (quo_u),
      .fits  (fits_u)
   );

   d2c_divider #(.QW(QW)) u_div_v (
      .clock (clock),
      .en    (en),
      .num   (front.num_v),
      .den   (front.den),
      .quo   (quo_v),
      .fits  (fits_v)
   );

   // sideband delay matching the divider depth
   always_ff @(posedge clock) begin
      if (reset) begin
         side_valid_ff <= '0;
      end else if (en) begin
         side_valid_ff <= QW'({side_valid_ff, front.valid});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].depth_ok <= front.depth_ok;
         side_ff[0].z_pos    <= front.z_pos;
         side_ff[0].pt_x     <= front.pt_x;
         side_ff[0].pt_y     <= front.pt_y;
         side_ff[0].pt_z     <= front.pt_z;
         for (int s = 1; s < QW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // ----- in-image decision and output register -----
   assign u_in = fits_u && ({1'b0, quo_u} < (QW+1)'(IMAGE_WIDTH));
   assign v_in = fits_v && ({1'b0, quo_v} < (QW+1)'(IMAGE_HEIGHT));
   assign hit  = side_ff[QW-1].depth_ok && side_ff[QW-1].z_pos && u_in && v_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_user_ff <= {hit, side_ff[QW-1].depth_ok};
         // invalid depth zeroes the point, a miss zeroes the target
         rsp_data_ff[15:0]  <= side_ff[QW-1].depth_ok ? side_ff[QW-1].pt_x : 16'd0;
         rsp_data_ff[31:16] <= side_ff[QW-1].depth_ok ? side_ff[QW-1].pt_y : 16'd0;
         rsp_data_ff[47:32] <= side_ff[QW-1].depth_ok ? side_ff[QW-1].pt_z : 16'd0;
         rsp_data_ff[57:48] <= hit ? 10'(quo_u) : 10'd0;
         rsp_data_ff[66:58] <= hit ? 9'(quo_v) : 9'd0;
         rsp_data_ff[71:67] <= '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> hdl/d2c_checker.sv
// ----------------------------------------------------------------------------
// d2c_checker
// port level checks on the result stream of the registration core
// ----------------------------------------------------------------------------
module d2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // a hit needs a valid depth
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("in_image without depth_ok");

   // invalid depth gives an all zero item
   a_zero_pt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 72'd0)
      else $error("invalid depth with non-zero payload");

   // a miss gives a zero target
   a_zero_tgt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[66:48] == 19'd0)
      else $error("miss with non-zero target");

endmodule

bind depth_to_color_registration_core d2c_checker u_d2c_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/tb_depth_to_color_registration_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_color_registration_core
// self-checking bench for the depth to colour registration core
// ----------------------------------------------------------------------------
// Depth items go in as bursts with random gaps while the result side stalls on
// its own pattern. Each result is checked field by field against a fixed point
// projection model kept in the bench or a value typed in the directed table,
// over several camera settings including the extremes of the register ranges.
module tb_depth_to_color_registration_core;
   import d2c_pkg::*;

   localparam int IMG_W = 640;
   localparam int IMG_H = 480;

   typedef struct packed {
      logic               depth_ok;
      logic               in_image;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [9:0]         col;
      logic [8:0]         row;
   } pix_res_t;

   typedef struct {
      logic [9:0]  col;
      logic [8:0]  row;
      logic [15:0] depth;
      bit          typed;     // expected value typed in the table
      pix_res_t    want;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // bench copy of the camera configuration
   logic [47:0] m_ifoc;
   logic [39:0] m_dprin, m_cfoc, m_cprin;
   logic [63:0] m_pose [3];
   logic [31:0] m_lim;

   pix_res_t pending_results [$];
   int       n_errors = 0;
   int       n_checked = 0;
   int       n_hits = 0;
   int       n_rejects = 0;

   always #5 clock = ~clock;

   depth_to_color_registration_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // ---------------------------------------------------------------- model
   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
      return q;
   endfunction

   // round half towards +inf on a right shift
   function automatic longint rshift_round(longint v, int s);
      return fdiv(v + (longint'(1) << (s - 1)), longint'(1) << s);
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint rotate_row(logic [63:0] r, longint x, longint y, longint z);
      longint acc;
      acc = longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y
          + longint'($signed(r[47:32])) * z + longint'($signed(r[63:48])) * (longint'(1) << 22);
      return rshift_round(acc, 14);
   endfunction

   function automatic pix_res_t register_pixel(logic [9:0] c, logic [8:0] r, logic [15:0] d);
      pix_res_t res;
      longint   xd, yd, zd, px, py, pz, u, v;
      res = '0;
      if (d < m_lim[15:0] || d > m_lim[31:16]) return res;
      res.depth_ok = 1'b1;
      xd = rshift_round((longint'(c) * 256 - longint'(m_dprin[19:0])) * longint'(d)
                        * longint'(m_ifoc[23:0]), 24);
      yd = rshift_round((longint'(r) * 256 - longint'(m_dprin[39:20])) * longint'(d)
                        * longint'(m_ifoc[47:24]), 24);
      zd = longint'(d) * 256;
      px = rotate_row(m_pose[0], xd, yd, zd);
      py = rotate_row(m_pose[1], xd, yd, zd);
      pz = rotate_row(m_pose[2], xd, yd, zd);
      res.px = 16'(clip16(rshift_round(px, 8)));
      res.py = 16'(clip16(rshift_round(py, 8)));
      res.pz = 16'(clip16(rshift_round(pz, 8)));
      if (pz > 0) begin
         u = fdiv(px * longint'(m_cfoc[19:0]) + longint'(m_cprin[19:0]) * pz, pz * 256);
         v = fdiv(py * longint'(m_cfoc[39:20]) + longint'(m_cprin[39:20]) * pz, pz * 256);
         if (u >= 0 && u < IMG_W && v >= 0 && v < IMG_H) begin
            res.in_image = 1'b1;
            res.col = 10'(u);
            res.row = 9'(v);
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------- checking
   task automatic report(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   // results are sampled at the rising edge, on the handshake
   always @(posedge clock) begin
      pix_res_t got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.depth_ok = rsp_tuser[0];
         got.in_image = rsp_tuser[1];
         got.px  = rsp_tdata[15:0];
         got.py  = rsp_tdata[31:16];
         got.pz  = rsp_tdata[47:32];
         got.col = rsp_tdata[57:48];
         got.row = rsp_tdata[66:58];
         if (pending_results.size() == 0) begin
            report("result item count", 1, 0);
         end else begin
            exp_r = pending_results.pop_front();
            n_checked++;
            if (exp_r.in_image) n_hits++;
            if (!exp_r.depth_ok) n_rejects++;
            if (got.depth_ok !== exp_r.depth_ok) report("depth_ok", got.depth_ok, exp_r.depth_ok);
            if (got.in_image !== exp_r.in_image) report("in_image", got.in_image, exp_r.in_image);
            if (got.px !== exp_r.px) report("point_x_mm", got.px, exp_r.px);
            if (got.py !== exp_r.py) report("point_y_mm", got.py, exp_r.py);
            if (got.pz !== exp_r.pz) report("point_z_mm", got.pz, exp_r.pz);
            if (got.col !== exp_r.col) report("target_column", got.col, exp_r.col);
            if (got.row !== exp_r.row) report("target_row", got.row, exp_r.row);
         end
      end
   end

   // receiver stall pattern: phases of always ready, sparse and dense stalls
   always @(posedge clock) begin
      int mode_ctr;
      int mode;
      if (mode_ctr == 0) begin
         mode_ctr = $urandom_range(10, 120);
         mode = $urandom_range(0, 2);
      end
      mode_ctr--;
      case (mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // -------------------------------------------------------------- driving
   int burst_left = 0;

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEPTH_INV_FOCAL: m_ifoc  = val[47:0];
         CSR_DEPTH_PRINCIPAL: m_dprin = val[39:0];
         CSR_COLOR_FOCAL:     m_cfoc  = val[39:0];
         CSR_COLOR_PRINCIPAL: m_cprin = val[39:0];
         CSR_POSE_ROW_X:      m_pose[0] = val;
         CSR_POSE_ROW_Y:      m_pose[1] = val;
         CSR_POSE_ROW_Z:      m_pose[2] = val;
         CSR_DEPTH_LIMITS:    m_lim   = val[31:0];
         default: ;
      endcase
   endtask

   // one depth item, with burst gaps; valid stays high across back to back items
   task automatic send_pixel(logic [9:0] c, logic [8:0] r, logic [15:0] d, pix_res_t want);
      if (burst_left == 0) begin
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, d, r, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(want);
   endtask

   task automatic send_modelled(logic [9:0] c, logic [8:0] r, logic [15:0] d);
      send_pixel(c, r, d, register_pixel(c, r, d));
   endtask

   // drop valid, wait for the pipe to empty, then let it settle
   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [63:0] pose_word(int r0, int r1, int r2, int t);
      return {16'(t), 16'(r2), 16'(r1), 16'(r0)};
   endfunction

   // mostly small realistic depths, some across the whole range
   task automatic random_pixels(int count);
      logic [15:0] d;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: d = 16'($urandom_range(0, 65535));
            1: d = 16'($urandom_range(0, 400));
            default: d = 16'($urandom_range(250, 12000));
         endcase
         if ($urandom_range(0, 19) == 0)
            send_modelled(10'($urandom), 9'($urandom), d);
         else
            send_modelled(10'($urandom_range(0, 639)), 9'($urandom_range(0, 479)), d);
      end
   endtask

   stim_row_t directed [$];

   function automatic stim_row_t mk(int c, int r, int d, bit t = 0, pix_res_t w = '0);
      stim_row_t s;
      s.col = 10'(c); s.row = 9'(r); s.depth = 16'(d); s.typed = t; s.want = w;
      return s;
   endfunction

   initial begin
      pix_res_t zero_res;
      pix_res_t centre_res;
      zero_res = '0;
      // pixel half a pixel past the principal point at 1 m on the reset cameras:
      // about 1 mm off axis, lands on colour pixel (320, 240), half a pixel past its principal point
      centre_res = '{1'b1, 1'b1, 16'sd1, 16'sd1, 16'sd1000, 10'd320, 9'd240};

      m_ifoc = RST_DEPTH_INV_FOCAL; m_dprin = RST_DEPTH_PRINCIPAL;
      m_cfoc = RST_COLOR_FOCAL;     m_cprin = RST_COLOR_PRINCIPAL;
      m_pose[0] = RST_POSE_ROW_X; m_pose[1] = RST_POSE_ROW_Y; m_pose[2] = RST_POSE_ROW_Z;
      m_lim = RST_DEPTH_LIMITS;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table on reset settings
      directed.push_back(mk(0, 0, 0, 1, zero_res));          // no reading
      directed.push_back(mk(320, 240, 299, 1, zero_res));    // just under the minimum
      directed.push_back(mk(320, 240, 10001, 1, zero_res));  // just over the maximum
      directed.push_back(mk(320, 240, 65535, 1, zero_res));  // top of the depth field
      directed.push_back(mk(320, 240, 1000, 1, centre_res));
      directed.push_back(mk(320, 240, 300));                 // limits inclusive
      directed.push_back(mk(320, 240, 10000));
      directed.push_back(mk(0, 0, 300));
      directed.push_back(mk(639, 479, 10000));
      directed.push_back(mk(0, 479, 5000));
      directed.push_back(mk(639, 0, 5000));
      directed.push_back(mk(1023, 511, 3000));               // beyond the image
      directed.push_back(mk(1023, 0, 10000));
      directed.push_back(mk(0, 511, 700));
      directed.push_back(mk(682, 341, 10000));
      directed.push_back(mk(341, 170, 1365));
      foreach (directed[i]) begin
         if (directed[i].typed)
            send_pixel(directed[i].col, directed[i].row, directed[i].depth, directed[i].want);
         else
            send_modelled(directed[i].col, directed[i].row, directed[i].depth);
      end
      random_pixels(150);
      // sender holds off until every result is back
      drain();

      // full range limits: zero depth becomes valid with zero z before the pose; rotated rig
      csr_write(CSR_DEPTH_LIMITS, 64'hFFFF_0000);
      csr_write(CSR_POSE_ROW_X, pose_word(16000, -2000, 1500, -50));
      csr_write(CSR_POSE_ROW_Y, pose_word(2000, 16200, -900, 25));
      csr_write(CSR_POSE_ROW_Z, pose_word(-1500, 900, 16300, 10));
      send_modelled(320, 240, 0);
      send_modelled(0, 0, 65535);
      send_modelled(639, 479, 65535);
      random_pixels(200);
      drain();

      // extreme camera words and saturating pose
      csr_write(CSR_DEPTH_INV_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_DEPTH_PRINCIPAL, '0);
      csr_write(CSR_COLOR_FOCAL, 64'hFF_FFFF_FFFF);
      csr_write(CSR_COLOR_PRINCIPAL, 64'hFF_FFFF_FFFF);
      csr_write(CSR_POSE_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
      csr_write(CSR_POSE_ROW_Y, 64'h8000_8000_8000_8000);
      csr_write(CSR_POSE_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_DEPTH_LIMITS, 64'h0000_0000);            // only zero depth passes
      send_modelled(0, 0, 0);
      send_modelled(1023, 511, 1);
      drain();
      csr_write(CSR_DEPTH_LIMITS, 64'hFFFF_0000);
      random_pixels(100);
      drain();

      // zero focal and colour principal words, maximal depth principal, negative z: nothing lands in the image
      csr_write(CSR_DEPTH_INV_FOCAL, '0);
      csr_write(CSR_DEPTH_PRINCIPAL, 64'hFF_FFFF_FFFF);
      csr_write(CSR_COLOR_FOCAL, '0);
      csr_write(CSR_COLOR_PRINCIPAL, '0);
      csr_write(CSR_POSE_ROW_Z, pose_word(0, 0, -16384, 0));
      random_pixels(100);
      drain();

      // back to a plausible rig with random small pose and camera offsets
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(CSR_DEPTH_INV_FOCAL, 64'({24'(31957 + $urandom_range(0, 4000)),
                                             24'(31957 - $urandom_range(0, 4000))}));
         csr_write(CSR_DEPTH_PRINCIPAL, 64'({20'($urandom_range(50000, 70000)),
                                             20'($urandom_range(70000, 95000))}));
         csr_write(CSR_COLOR_FOCAL, 64'({20'($urandom_range(110000, 160000)),
                                         20'($urandom_range(110000, 160000))}));
         csr_write(CSR_COLOR_PRINCIPAL, 64'({20'($urandom_range(50000, 70000)),
                                             20'($urandom_range(70000, 95000))}));
         csr_write(CSR_POSE_ROW_X, pose_word(16384 - $urandom_range(0, 300),
                   $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                   $urandom_range(0, 200) - 100));
         csr_write(CSR_POSE_ROW_Y, pose_word($urandom_range(0, 600) - 300,
                   16384 - $urandom_range(0, 300), $urandom_range(0, 600) - 300,
                   $urandom_range(0, 200) - 100));
         csr_write(CSR_POSE_ROW_Z, pose_word($urandom_range(0, 600) - 300,
                   $urandom_range(0, 600) - 300, 16384 - $urandom_range(0, 300),
                   $urandom_range(0, 200) - 100));
         csr_write(CSR_DEPTH_LIMITS, 64'({16'($urandom_range(4000, 20000)),
                                          16'($urandom_range(0, 600))}));
         random_pixels(170);
         drain();
      end

      $display("%0d results checked: %0d inside the colour image, %0d rejected on depth",
               n_checked, n_hits, n_rejects);
      $display("register settings covered: reset, full range, extremes, zero and random rigs");
      if (n_errors == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
